/* src/trimmed_moving_average_macros.svh */
// assertion macros for the trimmed moving average block
// used by files that check their own logic; needs clk and rst_n in scope
`ifndef TRIMMED_MOVING_AVERAGE_MACROS_SVH
`define TRIMMED_MOVING_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define TMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define TMA_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TMA_ASSERT(label, prop, msg)
`define TMA_NEVER(label, cond, msg)

`endif

`endif

/* src/tma_pkg.sv */
// shared types, sizes and state codes of the trimmed moving average block
// no dependencies
`timescale 1ns / 1ps

package tma_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int SAMPLE_W   = 32;
    localparam int CNT_W      = 7;
    localparam int SUM_W      = SAMPLE_W + ADDR_W;
    localparam int FRAC_W     = 8;
    localparam int DVD_W      = SUM_W + 1 + FRAC_W;
    localparam int STEP_W     = $clog2(DVD_W + 1);
    localparam int MEAN_W     = 40;

    localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(8);
    localparam logic [CNT_W-1:0] WINDOW_MAX   = CNT_W'(MAX_WINDOW);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } item_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_q8;
        logic [CNT_W-1:0]         valid_count;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIM,
        ST_START,
        ST_DIV
    } state_t;

endpackage

/* src/tma_ring_ram.sv */
// sample ring storage: one write port, one registered read port
// depends on tma_pkg
`timescale 1ns / 1ps

module tma_ring_ram
    import tma_pkg::*;
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic signed [SAMPLE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic signed [SAMPLE_W-1:0] rdata
);

    logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* src/tma_divider.sv */
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// depends on tma_pkg
`timescale 1ns / 1ps

module tma_divider
    import tma_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic signed [DVD_W-1:0] quotient,
    output div_status_t             status
);

    logic [DVD_W-1:0]  q_reg;
    logic [DVD_W-1:0]  q_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  d_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W:0]    shifted;
    logic [DVD_W-1:0]  magnitude;

    // magnitude of the incoming dividend
    assign magnitude = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);

    // one restoring step
    always_comb
    begin
        shifted   = {rem_reg, q_reg[DVD_W-1]};
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            q_next    = magnitude;
            step_next = STEP_W'(DVD_W);
            done_next = 1'b0;
        end
        else if (step_reg != '0)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                rem_next = CNT_W'(shifted - {1'b0, d_reg});
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CNT_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            d_reg   <= divisor;
            neg_reg <= dividend[DVD_W-1];
        end
    end

    // sign restored on the way out
    assign quotient    = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign status.busy = (step_reg != '0);
    assign status.done = done_reg;

endmodule

/* src/trimmed_moving_average.sv */
// top level of the trimmed moving average block: control, scan and result
// depends on tma_pkg, tma_ring_ram, tma_divider and the assertion macros
`timescale 1ns / 1ps

// Each accepted beat stores its sample in a ring of window_size entries
// (reset 8, at most 64; writing window_size empties the ring, a write of zero
// is ignored, larger values saturate to 64) and yields one result beat: the
// mean of the held samples in Q8, truncated toward zero, with the lowest and
// highest sample dropped when more than two are held, plus the held count.
// A set restart bit empties the ring before its sample is stored. A beat is
// taken only when idle and worked through before the next: one ring read per
// held sample through the single read port, then a 47-step serial divide;
// the result loads once the output register is free. A new beat is taken
// while the previous result waits in the output register.

`include "trimmed_moving_average_macros.svh"

module trimmed_moving_average
    import tma_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             window_we,
    input  logic [CNT_W-1:0] window_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result
);

    state_t                     state_reg;
    state_t                     state_next;
    logic [CNT_W-1:0]           ws_reg;
    logic [ADDR_W-1:0]          wp_reg;
    logic [CNT_W-1:0]           fc_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       pend_reg;
    logic                       result_valid_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic signed [SAMPLE_W-1:0] hi_reg;
    logic signed [DVD_W-1:0]    dividend_reg;
    result_t                    result_reg;

    logic                       accept;
    logic                       scan_issue;
    logic                       div_start;
    logic                       load_result;
    logic [ADDR_W-1:0]          wp_eff;
    logic [ADDR_W-1:0]          wp_next;
    logic [CNT_W-1:0]           fc_base;
    logic [CNT_W-1:0]           fc_next;
    logic [CNT_W-1:0]           win_clamped;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic signed [SUM_W:0]      trimmed;
    logic [CNT_W-1:0]           divisor;
    logic signed [DVD_W-1:0]    quotient;
    div_status_t                div_stat;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((cnt_reg == fc_reg) && pend_reg)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done && (!result_valid_reg || result_ready))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_ready  = 1'b0;
        scan_issue  = 1'b0;
        div_start   = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            ST_SCAN:
            begin
                scan_issue = (cnt_reg < fc_reg);
            end
            ST_START:
            begin
                div_start = 1'b1;
            end
            ST_DIV:
            begin
                load_result = div_stat.done && (!result_valid_reg || result_ready);
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    assign accept = item_valid && item_ready;

    // write slot and fill count for the incoming beat
    always_comb
    begin
        wp_eff  = item.restart ? '0 : wp_reg;
        fc_base = item.restart ? '0 : fc_reg;
        if (CNT_W'(wp_eff) >= ws_reg)
        begin
            wp_eff = '0;
        end
        fc_next = (fc_base < ws_reg) ? fc_base + CNT_W'(1) : fc_base;
        wp_next = wp_eff + ADDR_W'(1);
        if ((CNT_W'(wp_eff) + CNT_W'(1)) >= ws_reg)
        begin
            wp_next = '0;
        end
    end

    // window register value after saturation
    assign win_clamped = (window_data > WINDOW_MAX) ? WINDOW_MAX : window_data;

    // ring storage
    tma_ring_ram u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_eff),
        .wdata (item.sample),
        .raddr (cnt_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ws_reg           <= WINDOW_RESET;
            wp_reg           <= '0;
            fc_reg           <= '0;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (window_we && (window_data != '0))
            begin
                ws_reg <= win_clamped;
                wp_reg <= '0;
                fc_reg <= '0;
            end
            else if (accept)
            begin
                wp_reg <= wp_next;
                fc_reg <= fc_next;
            end
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (scan_issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            pend_reg <= scan_issue;
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // running sum, minimum and maximum over the scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg <= '0;
            lo_reg  <= SAMPLE_MAX;
            hi_reg  <= SAMPLE_MIN;
        end
        else if (pend_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_data);
            if (rd_data < lo_reg)
            begin
                lo_reg <= rd_data;
            end
            if (rd_data > hi_reg)
            begin
                hi_reg <= rd_data;
            end
        end
    end

    // drop the extremes once more than two samples are held
    always_comb
    begin
        if (fc_reg > CNT_W'(2))
        begin
            trimmed = (SUM_W+1)'(sum_reg)
                      - (SUM_W+1)'((SAMPLE_W+1)'(lo_reg) + (SAMPLE_W+1)'(hi_reg));
            divisor = fc_reg - CNT_W'(2);
        end
        else
        begin
            trimmed = (SUM_W+1)'(sum_reg);
            divisor = fc_reg;
        end
    end

    // dividend in Q8
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TRIM)
        begin
            dividend_reg <= {trimmed, {FRAC_W{1'b0}}};
        end
    end

    // serial divide
    tma_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_stat)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg.mean_q8     <= quotient[MEAN_W-1:0];
            result_reg.valid_count <= fc_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks on the ring bookkeeping and the sequencing
    `TMA_ASSERT(a_fill_in_window, (fc_reg <= ws_reg), "fill count exceeds window size")
    `TMA_ASSERT(a_accept_fills, (accept && !window_we) |=> ((fc_reg != '0) && (CNT_W'(wp_reg) < ws_reg)), "ring bookkeeping wrong after beat")
    `TMA_NEVER(a_div_outside, (div_stat.busy && (state_reg != ST_DIV)), "divider busy outside divide state")
    `TMA_NEVER(a_load_over_full, (load_result && result_valid_reg && !result_ready), "result overwritten before taken")

endmodule

/* tb/sv/trimmed_moving_average_tb.sv */
// self-checking testbench for the trimmed moving average block
// depends on tma_pkg and trimmed_moving_average; predicts every result beat in place
`timescale 1ns / 1ps

module trimmed_moving_average_tb
    import tma_pkg::*;
();

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 150;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_SAMPLES  = 115;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             window_we    = 1'b0;
    logic [CNT_W-1:0] window_data  = '0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    item_t            sample_beat  = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          result_beat;

    // stimulus and scoreboard state
    item_t   pending_samples[$];
    result_t expected_averages[$];
    bit      item_fire;
    bit      sender_idles    = 1'b1;
    bit      receiver_stalls = 1'b1;
    int      beats_popped    = 0;
    int      results_seen    = 0;
    int      error_count     = 0;
    int      window_writes   = 0;
    int      restart_count   = 0;
    int      cycle_count     = 0;

    // shadow copy of the ring and its pointers
    logic signed [SAMPLE_W-1:0] ring_copy [MAX_WINDOW];
    int unsigned window_len = WINDOW_RESET;
    int unsigned wr_slot    = 0;
    int unsigned held_count = 0;

    trimmed_moving_average u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_we    (window_we),
        .window_data  (window_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (sample_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_beat)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void push_sample(input logic signed [SAMPLE_W-1:0] value,
                                        input logic restart);
        item_t beat;
        beat.sample  = value;
        beat.restart = restart;
        if (restart)
            restart_count++;
        pending_samples.push_back(beat);
    endfunction

    // block is idle once every offered beat has produced its result
    task automatic wait_idle();
        while (pending_samples.size() != 0 || beats_popped != results_seen)
            @(negedge clk);
    endtask

    task automatic write_window(input logic [CNT_W-1:0] value);
        wait_idle();
        repeat (4) @(negedge clk);
        window_data <= value;
        window_we   <= 1'b1;
        window_writes++;
        @(negedge clk);
        window_we   <= 1'b0;
    endtask

    // window register and sample beats update the shadow ring, one prediction per beat
    always @(posedge clk)
    begin : average_predictor
        longint                     total;
        longint                     quotient;
        logic signed [SAMPLE_W-1:0] lowest;
        logic signed [SAMPLE_W-1:0] highest;
        int unsigned                divisor;
        result_t                    predicted;
        item_fire = rst_n && item_valid && item_ready;
        // zero is ignored, oversize saturates, any taken write empties the ring
        if (rst_n && window_we && window_data != '0)
        begin
            window_len = (window_data > WINDOW_MAX) ? MAX_WINDOW : window_data;
            wr_slot    = 0;
            held_count = 0;
        end
        if (item_fire)
        begin
            if (sample_beat.restart)
            begin
                wr_slot    = 0;
                held_count = 0;
            end
            if (wr_slot >= window_len)
                wr_slot = 0;
            if (held_count < window_len)
                held_count++;
            ring_copy[wr_slot] = sample_beat.sample;
            wr_slot++;
            if (wr_slot >= window_len)
                wr_slot = 0;
            // held entries always sit in slots 0 to held_count-1
            total   = 0;
            lowest  = SAMPLE_MAX;
            highest = SAMPLE_MIN;
            for (int i = 0; i < held_count; i++)
            begin
                total += ring_copy[i];
                if (ring_copy[i] > highest)
                    highest = ring_copy[i];
                if (ring_copy[i] < lowest)
                    lowest = ring_copy[i];
            end
            // drop one copy of min and max once more than two are held
            if (held_count > 2)
            begin
                total   = total - lowest - highest;
                divisor = held_count - 2;
            end
            else
            begin
                divisor = held_count;
            end
            quotient = (total * 256) / longint'(divisor);
            predicted.mean_q8     = quotient[MEAN_W-1:0];
            predicted.valid_count = held_count[CNT_W-1:0];
            expected_averages.push_back(predicted);
        end
    end

    // compare each result beat against the oldest prediction
    always @(posedge clk)
    begin : average_checker
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (expected_averages.size() == 0)
            begin
                $error("result beat with no sample waiting: mean_q8 %0d, valid_count %0d",
                       result_beat.mean_q8, result_beat.valid_count);
                error_count++;
            end
            else
            begin
                want = expected_averages.pop_front();
                if (result_beat.mean_q8 !== want.mean_q8)
                begin
                    $error("mean_q8 mismatch: expected %0d, got %0d",
                           want.mean_q8, result_beat.mean_q8);
                    error_count++;
                end
                if (result_beat.valid_count !== want.valid_count)
                begin
                    $error("valid_count mismatch: expected %0d, got %0d",
                           want.valid_count, result_beat.valid_count);
                    error_count++;
                end
            end
        end
    end

    // sample driver: holds each beat until taken, random gaps between beats
    always @(negedge clk)
    begin : sample_driver
        int unsigned send_gap;
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            sample_beat <= '0;
            send_gap     = 0;
        end
        else if (!item_valid || item_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                sample_beat <= pending_samples.pop_front();
                item_valid  <= 1'b1;
                beats_popped++;
                send_gap = sender_idles ? pick_gap() : 0;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // result sink: random stalls plus long hold-offs that back up the input
    always @(negedge clk)
    begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        int          next_hold_at;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left    = 0;
            hold_left     = 0;
            next_hold_at  = 300;
        end
        else
        begin
            if (hold_left == 0 && results_seen >= next_hold_at
                && pending_samples.size() > 20)
            begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = results_seen + 500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (receiver_stalls && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_averages.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic signed [SAMPLE_W-1:0] value;
        logic signed [SAMPLE_W-1:0] last_value;
        logic [CNT_W-1:0]           width_choice;
        int unsigned                r;

        last_value = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset window of 8, trimming, ties, wrap, restart
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(1, 1'b0);
        push_sample(-2, 1'b0);
        push_sample(3, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        // zero write must leave the ring alone
        write_window('0);
        push_sample(5, 1'b0);
        push_sample(-5, 1'b0);
        push_sample(7, 1'b1);
        push_sample(-7, 1'b0);
        push_sample(2, 1'b0);
        // oversize write saturates to the full window
        write_window(7'd127);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        write_window(7'd1);
        push_sample(-3, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b1);
        write_window(7'd2);
        push_sample(-1, 1'b0);
        push_sample(-2, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);

        // random phases, each under its own window setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                width_choice = WINDOW_MAX;
            else if (phase == 1)
                width_choice = 7'd1;
            else if (phase == 2)
                width_choice = 7'd3;
            else
            begin
                case ($urandom_range(0, 5))
                    0: width_choice = '0;
                    1: width_choice = CNT_W'($urandom_range(1, 4));
                    2: width_choice = CNT_W'($urandom_range(5, 16));
                    3: width_choice = CNT_W'($urandom_range(17, 64));
                    4: width_choice = CNT_W'($urandom_range(65, 127));
                    default: width_choice = CNT_W'($urandom_range(1, 127));
                endcase
            end
            write_window(width_choice);
            sender_idles    = (phase % 4 != 3) && ($urandom_range(0, 4) != 0);
            receiver_stalls = (phase % 4 != 3) && ($urandom_range(0, 4) != 0);
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                // first phase leans on large magnitudes to push the sum past 32 bits
                r = (phase == 0) ? $urandom_range(55, 70) : $urandom_range(0, 99);
                if (r < 30)
                    value = $urandom;
                else if (r < 55)
                    value = int'($urandom_range(0, 64)) - 32;
                else if (r < 65)
                    value = SAMPLE_MAX - int'($urandom_range(0, 3));
                else if (r < 75)
                    value = SAMPLE_MIN + int'($urandom_range(0, 3));
                else if (r < 88)
                    value = last_value;
                else
                    value = 32'sd1 <<< $urandom_range(0, 31);
                last_value = value;
                push_sample(value, $urandom_range(0, 24) == 0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_averages.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_averages.size());
            error_count++;
        end
        $display("summary: %0d sample beats checked under %0d window writes, %0d restarts",
                 results_seen, window_writes, restart_count);
        $display("summary: %0d field mismatches or stray beats", error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
